@@ rtl/core/pqs_pkg.sv @@
`default_nettype none

package pqs_pkg;

    // Field widths of the transaction payloads
    localparam int SLOT_W     = 4;
    localparam int TIME_W     = 16;
    localparam int PRIO_W     = 8;
    localparam int NOW_W      = 32;
    localparam int SLICE_W    = 8;
    localparam int JOBS_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // One job table entry holds priority, arrival and remaining ticks
    localparam int ENT_W = PRIO_W + TIME_W + TIME_W;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(2);
    localparam logic [JOBS_W-1:0]  JOBS_RESET  = '0;
    localparam logic [NOW_W-1:0]   NOW_MAX     = '1;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE_LENGTH = 1'b0,
        CFG_JOBS_IN_USE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_PICK,
        ST_FETCH,
        ST_RUN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic scan;
        logic pick;
        logic fetch;
        logic run;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_sel;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/core/pqs_req_if.sv @@
`default_nettype none

interface pqs_req_if;
    import pqs_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [SLOT_W-1:0] job_slot;
    logic [TIME_W-1:0] job_arrival;
    logic [PRIO_W-1:0] job_priority;
    logic [TIME_W-1:0] job_length;

    modport source (
        output valid, req_type, job_slot, job_arrival, job_priority, job_length,
        input  ready
    );

    modport sink (
        input  valid, req_type, job_slot, job_arrival, job_priority, job_length,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/pqs_res_if.sv @@
`default_nettype none

interface pqs_res_if;
    import pqs_pkg::*;

    logic              valid;
    logic              ready;
    logic              ran_valid;
    logic [SLOT_W-1:0] ran_job;
    logic              job_done;
    logic              all_done;
    logic [NOW_W-1:0]  now_time;

    modport source (
        output valid, ran_valid, ran_job, job_done, all_done, now_time,
        input  ready
    );

    modport sink (
        input  valid, ran_valid, ran_job, job_done, all_done, now_time,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/pqs_ctrl.sv @@
`default_nettype none

module pqs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_type,
    output logic               o_in_ready,
    input  wire pqs_pkg::t_sts i_sts,
    output pqs_pkg::t_cmd      o_cmd
);
    import pqs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in_type == REQ_TICK) ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP:  n_state = i_sts.need_sel ? ST_SCAN : ST_FETCH;
            ST_SCAN:  n_state = i_sts.scan_end ? ST_PICK : ST_SCAN;
            ST_PICK:  n_state = ST_FETCH;
            ST_FETCH: n_state = ST_RUN;
            ST_RUN:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && (i_in_type == REQ_LOAD);
            end
            ST_PREP:  o_cmd.prep  = 1'b1;
            ST_SCAN:  o_cmd.scan  = 1'b1;
            ST_PICK:  o_cmd.pick  = 1'b1;
            ST_FETCH: o_cmd.fetch = 1'b1;
            ST_RUN:   o_cmd.run   = 1'b1;
            ST_DONE:  o_cmd.push  = i_sts.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pqs_dpath.sv @@
`default_nettype none

module pqs_dpath #(
    parameter int TABLE_DEPTH = pqs_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pqs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pqs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire pqs_pkg::t_cmd                    i_cmd,
    output pqs_pkg::t_sts                         o_sts,
    input  wire logic [pqs_pkg::SLOT_W-1:0]       i_job_slot,
    input  wire logic [pqs_pkg::TIME_W-1:0]       i_job_arrival,
    input  wire logic [pqs_pkg::PRIO_W-1:0]       i_job_priority,
    input  wire logic [pqs_pkg::TIME_W-1:0]       i_job_length,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_ran_valid,
    output logic [pqs_pkg::SLOT_W-1:0]            o_ran_job,
    output logic                                  o_job_done,
    output logic                                  o_all_done,
    output logic [pqs_pkg::NOW_W-1:0]             o_now_time
);
    import pqs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Job table and its read register
    logic [ENT_W-1:0] mem [TABLE_DEPTH];
    logic [ENT_W-1:0] r_rd;
    logic [IDX_W-1:0] rd_addr;

    // Scheduler state
    logic [TABLE_DEPTH-1:0] r_fin;
    logic                   r_act_valid;
    logic [IDX_W-1:0]       r_active;
    logic [SLICE_W-1:0]     r_slice_left;
    logic [NOW_W-1:0]       r_tick;
    logic [SLICE_W-1:0]     r_slice_len;
    logic [JOBS_W-1:0]      r_jobs;

    // Selection scan
    logic [CNT_W-1:0]       r_addr;
    logic                   r_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_found;
    logic [ENT_W-1:0]       r_best_key;
    logic [IDX_W-1:0]       r_best_idx;

    // Pending result
    logic                   r_res_ran;
    logic [SLOT_W-1:0]      r_res_job;
    logic                   r_res_done;

    logic [CNT_W-1:0]       n_used;
    logic                   stale;
    logic                   slot_ok;
    logic                   eligible;
    logic                   take;
    logic [TIME_W-1:0]      cur_rem;
    logic [TIME_W-1:0]      n_rem;
    logic                   all_fin;

    // Clamp the used count to the table depth
    assign n_used = (32'(r_jobs) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(r_jobs);

    assign stale = r_act_valid &&
                   ((32'(r_active) >= 32'(n_used)) || r_fin[r_active]);

    assign slot_ok = 32'(i_job_slot) < TABLE_DEPTH;

    // Compare the entry fetched in the previous scan cycle
    assign eligible = r_cmp_vld && !r_fin[r_cmp_idx] &&
                      (32'(r_rd[2*TIME_W-1:TIME_W]) <= r_tick) &&
                      !(r_act_valid && (r_cmp_idx == r_active));
    assign take = eligible && (!r_found || (r_rd < r_best_key));

    assign cur_rem = r_rd[TIME_W-1:0];
    assign n_rem   = (cur_rem == '0) ? '0 : cur_rem - TIME_W'(1);

    assign rd_addr = i_cmd.scan ? r_addr[IDX_W-1:0] : r_active;

    always_comb begin
        all_fin = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if ((i < 32'(n_used)) && !r_fin[i]) begin
                all_fin = 1'b0;
            end
        end
    end

    assign o_sts.need_sel = (r_slice_left == '0) || !r_act_valid || stale;
    assign o_sts.scan_end = r_addr >= n_used;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // Job table: load writes an entry, run writes back remaining ticks
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            mem[IDX_W'(i_job_slot)] <= {i_job_priority, i_job_arrival, i_job_length};
        end else if (i_cmd.run && r_act_valid) begin
            mem[r_active] <= {r_rd[ENT_W-1:TIME_W], n_rem};
        end
        r_rd <= mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_len <= SLICE_RESET;
            r_jobs      <= JOBS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SLICE_LENGTH) begin
                r_slice_len <= i_cfg_data[SLICE_W-1:0];
            end else begin
                r_jobs <= i_cfg_data[JOBS_W-1:0];
            end
        end
    end

    // Scheduler state: clear on load, drop, select, run one tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin        <= '0;
            r_act_valid  <= 1'b0;
            r_active     <= '0;
            r_slice_left <= '0;
            r_tick       <= '0;
        end else begin
            if (i_cmd.load && slot_ok) begin
                r_fin[IDX_W'(i_job_slot)] <= 1'b0;
            end
            if (i_cmd.prep && stale) begin
                r_act_valid <= 1'b0;
            end
            if (i_cmd.pick) begin
                if (r_found) begin
                    r_active    <= r_best_idx;
                    r_act_valid <= 1'b1;
                end
                if (r_found || r_act_valid) begin
                    r_slice_left <= (r_slice_len == '0) ? SLICE_W'(1) : r_slice_len;
                end
            end
            if (i_cmd.run) begin
                if (r_act_valid) begin
                    r_slice_left <= r_slice_left - SLICE_W'(1);
                    if (n_rem == '0) begin
                        r_fin[r_active] <= 1'b1;
                        r_slice_left    <= '0;
                        r_act_valid     <= 1'b0;
                    end
                end
                if (r_tick != NOW_MAX) begin
                    r_tick <= r_tick + NOW_W'(1);
                end
            end
        end
    end

    // Scan counter and best candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.prep) begin
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= r_addr < n_used;
            r_cmp_idx <= r_addr[IDX_W-1:0];
            if (r_addr < n_used) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (take) begin
                r_found    <= 1'b1;
                r_best_key <= r_rd;
                r_best_idx <= r_cmp_idx;
            end
        end
    end

    // Pending result of the current transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_ran  <= 1'b0;
            r_res_job  <= '0;
            r_res_done <= 1'b0;
        end else if (i_cmd.run) begin
            r_res_ran  <= r_act_valid;
            r_res_job  <= r_act_valid ? SLOT_W'(r_active) : '0;
            r_res_done <= r_act_valid && (n_rem == '0);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_ran_valid <= r_res_ran;
            o_ran_job   <= r_res_job;
            o_job_done  <= r_res_done;
            o_all_done  <= all_fin;
            o_now_time  <= r_tick;
        end
    end

    a_done_implies_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_job_done || o_ran_valid))
        else $error("completion reported without a running job");

    a_tick_monotonic: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_tick >= $past(r_tick)))
        else $error("tick count went backwards");

    a_finish_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run && r_act_valid && (n_rem == '0)) |=> (!r_act_valid && r_fin[r_active]))
        else $error("completed job still holds the CPU");

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

@@ rtl/core/priority_quantum_scheduler_core.sv @@
`default_nettype none

// Tick-driven preemptive priority scheduler with a time slice. A load
// transaction writes one job table entry and goes straight to its result.
// A tick transaction that keeps the current job passes the prep, fetch, run
// and done states. One that must choose a job scans the job table between
// prep and pick, one entry per cycle through the single table read port,
// and then goes on to fetch. The next transaction is accepted
// once the result has moved to the output register, even while that result
// still waits to be taken. The job table has no reset: an entry below
// jobs_in_use must be loaded before a tick reads it.
module priority_quantum_scheduler_core #(
    parameter int TABLE_DEPTH = pqs_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pqs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pqs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pqs_req_if.sink                             i_req,
    pqs_res_if.source                           o_res
);
    import pqs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_type  (i_req.req_type),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pqs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_job_slot     (i_req.job_slot),
        .i_job_arrival  (i_req.job_arrival),
        .i_job_priority (i_req.job_priority),
        .i_job_length   (i_req.job_length),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_ran_valid    (o_res.ran_valid),
        .o_ran_job      (o_res.ran_job),
        .o_job_done     (o_res.job_done),
        .o_all_done     (o_res.all_done),
        .o_now_time     (o_res.now_time)
    );

endmodule

`default_nettype wire
